// ===== sv/pid_pkg.sv =====
`timescale 1ns / 1ps
// Package for the priority interrupt dispatch block: codes, word types,
// the source priority ROM and the level and bit-search helpers.
// No dependencies.
package pid_pkg;

   localparam int SOURCE_COUNT_DEFAULT = 32;
   localparam int NEST_DEPTH_DEFAULT   = 16;
   localparam int SRC_W                = 5;
   localparam int LVL_W                = 5;
   localparam int VEC_W                = 8;
   localparam int EVT_W                = 32;
   localparam logic [VEC_W-1:0] VECTOR_BASE_RESET = 8'd16;

   typedef enum logic [1:0] {
      OP_ENABLE  = 2'd0,
      OP_DISABLE = 2'd1,
      OP_ACK     = 2'd2,
      OP_EOS     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_RANGE    = 2'd1,
      ST_SPURIOUS = 2'd2,
      ST_NEST     = 2'd3
   } status_type;

   typedef struct packed {
      op_type           op;
      logic [VEC_W-1:0] vector;
      logic [EVT_W-1:0] events;
      logic             unclaimed;
   } req_word_type;

   typedef struct packed {
      status_type       status;
      logic [SRC_W-1:0] source_index;
      logic [VEC_W-1:0] vector_out;
      logic [LVL_W-1:0] level;
      logic [EVT_W-1:0] mask_word;
      logic [EVT_W-1:0] clear_word;
   } rsp_word_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic [SRC_W-1:0] source;
   } stack_entry_type;

   typedef struct packed {
      logic [SRC_W-1:0] pick;
      logic [LVL_W-1:0] level;
   } sel_result_type;

   localparam logic [LVL_W-1:0] PRIO_ROM [EVT_W] = '{
      5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15,
      5'd16, 5'd16, 5'd17, 5'd17, 5'd18, 5'd18, 5'd19, 5'd19,
      5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25,
      5'd25, 5'd25, 5'd24, 5'd25, 5'd25, 5'd25, 5'd26, 5'd27
   };

   // sources whose priority lies above lvl
   function automatic logic [EVT_W-1:0] level_mask(input logic [LVL_W-1:0] lvl);
      logic [EVT_W-1:0] m;
      m = '0;
      for (int n = 0; n < EVT_W; n++) begin
         m[n] = (PRIO_ROM[n] > lvl);
      end
      return m;
   endfunction

   // sources whose priority equals lvl
   function automatic logic [EVT_W-1:0] level_match(input logic [LVL_W-1:0] lvl);
      logic [EVT_W-1:0] m;
      m = '0;
      for (int n = 0; n < EVT_W; n++) begin
         m[n] = (PRIO_ROM[n] == lvl);
      end
      return m;
   endfunction

   // index of the highest set bit, binary search
   function automatic logic [SRC_W-1:0] msb_index(input logic [EVT_W-1:0] x);
      logic [EVT_W-1:0] v;
      logic [SRC_W-1:0] r;
      v = x;
      r = '0;
      for (int s = SRC_W - 1; s >= 0; s--) begin
         if ((v >> (1 << s)) != '0) begin
            r[s] = 1'b1;
            v    = v >> (1 << s);
         end
      end
      return r;
   endfunction

   function automatic logic [SRC_W-1:0] lsb_index(input logic [EVT_W-1:0] x);
      logic [EVT_W-1:0] iso;
      iso = x & (~x + EVT_W'(1));
      return msb_index(iso);
   endfunction

endpackage

// ===== sv/pid_select.sv =====
`timescale 1ns / 1ps
// Priority select: picks the pending source with the highest level.
// Depends on pid_pkg.
module pid_select
   import pid_pkg::*;
#(
   parameter int SOURCE_COUNT = SOURCE_COUNT_DEFAULT
) (
   input  logic [SOURCE_COUNT-1:0] pending,
   output sel_result_type          sel
);

   logic [EVT_W-1:0] pend_wide;
   logic [EVT_W-1:0] presence;
   logic [LVL_W-1:0] top_level;
   logic [SRC_W-1:0] high_src;
   logic [SRC_W-1:0] low_src;

   assign pend_wide = EVT_W'(pending);

   always_comb begin
      for (int v = 0; v < EVT_W; v++) begin
         presence[v] = |(pend_wide & level_match(LVL_W'(v)));
      end
   end

   assign top_level = msb_index(presence);
   assign high_src  = msb_index(pend_wide);
   assign low_src   = lsb_index(pend_wide & level_match(top_level));

   // highest pending bit wins if it already holds the top level
   always_comb begin
      sel.level = top_level;
      if (PRIO_ROM[high_src] == top_level) begin
         sel.pick = high_src;
      end else begin
         sel.pick = low_src;
      end
   end

endmodule

// ===== sv/priority_interrupt_dispatch.sv =====
`timescale 1ns / 1ps
// Priority interrupt dispatch: top level with registered set, level mask and nest stack.
// Depends on pid_pkg and pid_select.
//
// One request word is taken every clock cycle while req_stall is low. Its response word passes
// through the input register, then the response register, and it is held while rsp_stall is
// high. The request side stalls only while a response is held under rsp_stall and the input
// register is full. Each word is resolved combinationally against the set, mask, level and
// stack registers, which are updated as the word moves into the response register, so the
// next word sees the effect of the previous one.
// The nest stack is a small register file; no clearing pass is needed after reset.
module priority_interrupt_dispatch
   import pid_pkg::*;
#(
   parameter int SOURCE_COUNT = SOURCE_COUNT_DEFAULT,
   parameter int NEST_DEPTH   = NEST_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_word_type     rsp_word,
   input  logic             csr_write_enable,
   input  logic [VEC_W-1:0] csr_write_data
);

   localparam int CNT_W = $clog2(NEST_DEPTH + 1);
   localparam int IDX_W = $clog2(NEST_DEPTH);
   localparam logic [SOURCE_COUNT-1:0] ONE_BIT = SOURCE_COUNT'(1);

   logic                    in_valid_ff, in_valid_in;
   req_word_type            in_word_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff, rsp_in;
   logic [VEC_W-1:0]        vector_base_ff;
   logic [SOURCE_COUNT-1:0] set_ff, set_in;
   logic [SOURCE_COUNT-1:0] mask_ff, mask_in;
   logic [LVL_W-1:0]        level_ff, level_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   stack_entry_type         stack_ff [NEST_DEPTH];

   logic                    req_accept;
   logic                    advance;
   logic                    push;
   logic [CNT_W-1:0]        count_dec;
   logic [IDX_W-1:0]        wr_idx;
   logic [IDX_W-1:0]        rd_idx;
   stack_entry_type         push_entry;
   stack_entry_type         pop_entry;
   logic [SOURCE_COUNT-1:0] events_src;
   logic [SOURCE_COUNT-1:0] pending;
   sel_result_type          sel;
   logic [LVL_W-1:0]        push_level;
   logic [EVT_W-1:0]        lm_cur, lm_push, lm_pop;
   logic [VEC_W:0]          vec_wide, base_wide;
   logic                    out_of_range;
   logic [VEC_W-1:0]        vec_offset;
   logic [SRC_W-1:0]        addr_src;

   // handshake
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_accept   = req_valid && !req_stall;
   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;

   // stack addressing
   assign count_dec = count_ff - CNT_W'(1);
   assign wr_idx    = count_ff[IDX_W-1:0];
   assign rd_idx    = count_dec[IDX_W-1:0];
   assign pop_entry = stack_ff[rd_idx];

   // vector decode
   assign vec_wide     = {1'b0, in_word_ff.vector};
   assign base_wide    = {1'b0, vector_base_ff};
   assign out_of_range = (vec_wide < base_wide)
                      || (vec_wide >= base_wide + (VEC_W+1)'(SOURCE_COUNT));
   assign vec_offset   = in_word_ff.vector - vector_base_ff;
   assign addr_src     = vec_offset[SRC_W-1:0];

   // acknowledge selection
   assign events_src = in_word_ff.events[SOURCE_COUNT-1:0];
   assign pending    = events_src & mask_ff;

   pid_select #(
      .SOURCE_COUNT(SOURCE_COUNT)
   ) u_select (
      .pending(pending),
      .sel    (sel)
   );

   assign push_level        = (sel.level < level_ff) ? level_ff : sel.level;
   assign push_entry.level  = level_ff;
   assign push_entry.source = sel.pick;

   assign lm_cur  = level_mask(level_ff);
   assign lm_push = level_mask(push_level);
   assign lm_pop  = level_mask(pop_entry.level);

   always_comb begin
      rsp_in              = '0;
      rsp_in.status       = ST_DONE;
      set_in              = set_ff;
      mask_in             = mask_ff;
      level_in            = level_ff;
      count_in            = count_ff;
      push                = 1'b0;
      unique case (in_word_ff.op)
         OP_ENABLE, OP_DISABLE: begin
            if (out_of_range) begin
               rsp_in.status = ST_RANGE;
            end else begin
               if (in_word_ff.op == OP_ENABLE) begin
                  set_in            = set_ff | (ONE_BIT << addr_src);
                  rsp_in.clear_word = EVT_W'(ONE_BIT << addr_src);
               end else begin
                  set_in = set_ff & ~(ONE_BIT << addr_src);
               end
               mask_in             = lm_cur[SOURCE_COUNT-1:0] & set_in;
               rsp_in.source_index = addr_src;
               rsp_in.vector_out   = in_word_ff.vector;
            end
         end
         OP_ACK: begin
            if (pending == '0) begin
               rsp_in.status     = ST_SPURIOUS;
               rsp_in.clear_word = EVT_W'(events_src & ~mask_ff);
            end else if (count_ff == CNT_W'(NEST_DEPTH)) begin
               rsp_in.status = ST_NEST;
            end else begin
               push                = 1'b1;
               count_in            = count_ff + CNT_W'(1);
               level_in            = push_level;
               mask_in             = lm_push[SOURCE_COUNT-1:0] & set_ff
                                   & ~(ONE_BIT << sel.pick);
               rsp_in.source_index = sel.pick;
               rsp_in.vector_out   = vector_base_ff + VEC_W'(sel.pick);
               rsp_in.clear_word   = EVT_W'(ONE_BIT << sel.pick);
            end
         end
         OP_EOS: begin
            if (count_ff == '0) begin
               rsp_in.status = ST_NEST;
            end else begin
               count_in = count_dec;
               level_in = pop_entry.level;
               if (in_word_ff.unclaimed) begin
                  set_in = set_ff & ~(ONE_BIT << pop_entry.source);
               end
               mask_in             = lm_pop[SOURCE_COUNT-1:0] & set_in;
               rsp_in.source_index = pop_entry.source;
               rsp_in.vector_out   = vector_base_ff + VEC_W'(pop_entry.source);
            end
         end
         default: begin
            rsp_in.status = ST_DONE;
         end
      endcase
      rsp_in.level     = level_in;
      rsp_in.mask_word = EVT_W'(mask_in);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         vector_base_ff <= VECTOR_BASE_RESET;
         set_ff         <= '0;
         mask_ff        <= '0;
         level_ff       <= '0;
         count_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            vector_base_ff <= csr_write_data;
         end
         if (advance) begin
            set_ff   <= set_in;
            mask_ff  <= mask_in;
            level_ff <= level_in;
            count_ff <= count_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= rsp_in;
      end
      if (advance && push) begin
         stack_ff[wr_idx] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NEST_DEPTH))
      else $error("nest count beyond stack depth");

   a_mask_subset: assert property (@(posedge clock) disable iff (reset)
      (mask_ff & ~set_ff) == '0)
      else $error("live mask holds an unregistered source");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      advance && push |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("acknowledge did not grow the nest stack");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("input stalled without a held response");

endmodule

// ===== test/tb_priority_interrupt_dispatch.sv =====
`timescale 1ns / 1ps
// Testbench for priority_interrupt_dispatch: directed and random request words checked
// against an in-bench dispatch predictor, with random idling on both sides.
// Depends on pid_pkg and the priority_interrupt_dispatch RTL.
module tb_priority_interrupt_dispatch;
   import pid_pkg::*;

   localparam int SOURCES     = 32;
   localparam int NEST_LIMIT  = 16;
   localparam int HOLD_CYCLES = 60;
   localparam int CYCLE_LIMIT = 100000;
   localparam logic [7:0] BASE_AT_RESET = 8'd16;

   localparam logic [4:0] SOURCE_LEVEL [SOURCES] = '{
      5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15, 5'd15,
      5'd16, 5'd16, 5'd17, 5'd17, 5'd18, 5'd18, 5'd19, 5'd19,
      5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25,
      5'd25, 5'd25, 5'd24, 5'd25, 5'd25, 5'd25, 5'd26, 5'd27
   };

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_write_enable = 1'b0;
   logic [7:0]   csr_write_data = '0;

   bit          idle_on = 1'b1;
   logic        hold_request = 1'b0;
   logic [7:0]  base_setting = BASE_AT_RESET;
   int          cycle_count = 0;
   int          mismatch_count = 0;

   // predictor state
   logic [7:0]      base_q;
   logic [31:0]     reg_set;
   logic [31:0]     live;
   logic [4:0]      cur_lvl;
   stack_entry_type nest [NEST_LIMIT];
   int              nest_n;
   rsp_word_type    rsp_expect_q [$];

   priority_interrupt_dispatch dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [31:0] sources_above(input logic [4:0] lvl);
      logic [31:0] m;
      for (int n = 0; n < SOURCES; n++) begin
         m[n] = SOURCE_LEVEL[n] > lvl;
      end
      return m;
   endfunction

   function automatic rsp_word_type dispatch_model(input req_word_type w);
      rsp_word_type    r;
      logic [31:0]     pending;
      logic [31:0]     bit_w;
      int              idx;
      int              pick;
      logic [4:0]      new_lvl;
      stack_entry_type top;
      r = '0;
      r.status = ST_DONE;
      case (w.op)
         OP_ENABLE, OP_DISABLE: begin
            if (int'(w.vector) < int'(base_q) || int'(w.vector) >= int'(base_q) + SOURCES) begin
               r.status = ST_RANGE;
            end else begin
               idx   = int'(w.vector) - int'(base_q);
               bit_w = 32'd1 << idx;
               if (w.op == OP_ENABLE) begin
                  reg_set |= bit_w;
                  r.clear_word = bit_w;
               end else begin
                  reg_set &= ~bit_w;
               end
               live = sources_above(cur_lvl) & reg_set;
               r.source_index = 5'(idx);
               r.vector_out   = w.vector;
            end
         end
         OP_ACK: begin
            pending = w.events & live;
            if (pending == '0) begin
               r.status     = ST_SPURIOUS;
               r.clear_word = w.events & ~live;
            end else if (nest_n >= NEST_LIMIT) begin
               r.status = ST_NEST;
            end else begin
               pick = SOURCES - 1;
               while (!pending[pick]) pick--;
               for (int b = 0; b < SOURCES; b++) begin
                  if (pending[b] && SOURCE_LEVEL[b] > SOURCE_LEVEL[pick]) pick = b;
               end
               new_lvl = (SOURCE_LEVEL[pick] < cur_lvl) ? cur_lvl : SOURCE_LEVEL[pick];
               nest[nest_n].level  = cur_lvl;
               nest[nest_n].source = 5'(pick);
               nest_n++;
               cur_lvl = new_lvl;
               bit_w   = 32'd1 << pick;
               live    = sources_above(cur_lvl) & reg_set & ~bit_w;
               r.source_index = 5'(pick);
               r.vector_out   = base_q + 8'(pick);
               r.clear_word   = bit_w;
            end
         end
         default: begin
            if (nest_n == 0) begin
               r.status = ST_NEST;
            end else begin
               nest_n--;
               top = nest[nest_n];
               if (w.unclaimed) reg_set &= ~(32'd1 << top.source);
               cur_lvl = top.level;
               live    = sources_above(cur_lvl) & reg_set;
               r.source_index = top.source;
               r.vector_out   = base_q + 8'(top.source);
            end
         end
      endcase
      r.level     = cur_lvl;
      r.mask_word = live;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // predictor update on accepted words, check of accepted results
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         base_q  = BASE_AT_RESET;
         reg_set = '0;
         live    = '0;
         cur_lvl = '0;
         nest_n  = 0;
      end else begin
         if (csr_write_enable) base_q = csr_write_data;
         if (req_valid && !req_stall) rsp_expect_q.push_back(dispatch_model(req_word));
         if (rsp_valid && !rsp_stall) begin
            if (rsp_expect_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: no word expected, actual %0h", $time, rsp_word);
            end else begin
               want = rsp_expect_q.pop_front();
               compare_field("status", want.status, rsp_word.status);
               compare_field("source_index", want.source_index, rsp_word.source_index);
               compare_field("vector_out", want.vector_out, rsp_word.vector_out);
               compare_field("level", want.level, rsp_word.level);
               compare_field("mask_word", want.mask_word, rsp_word.mask_word);
               compare_field("clear_word", want.clear_word, rsp_word.clear_word);
            end
         end
      end
   end

   // receiver: random stall bursts, plus a long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_stall    <= 1'b1;
            for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_word_type req_of(input op_type op, input logic [7:0] vector,
                                           input logic [31:0] events, input logic unclaimed);
      req_word_type w;
      w.op        = op;
      w.vector    = vector;
      w.events    = events;
      w.unclaimed = unclaimed;
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_base(input logic [7:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      base_setting      = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_traffic(input int n_items);
      req_word_type w;
      int           r;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 25)      w.op = OP_ENABLE;
         else if (r < 35) w.op = OP_DISABLE;
         else if (r < 70) w.op = OP_ACK;
         else             w.op = OP_EOS;
         if ($urandom_range(0, 9) == 0) w.vector = 8'($urandom_range(0, 255));
         else w.vector = base_setting + 8'($urandom_range(0, SOURCES - 1));
         case ($urandom_range(0, 9))
            0:       w.events = '0;
            1:       w.events = '1;
            2, 3:    w.events = $urandom;
            default: begin
               w.events = 32'd1 << $urandom_range(0, 31);
               if ($urandom_range(0, 1)) w.events |= 32'd1 << $urandom_range(0, 31);
            end
         endcase
         w.unclaimed = ($urandom_range(0, 3) == 0);
         send_word(w);
      end
   endtask

   task automatic test_directed_cases();
      send_word(req_of(OP_ENABLE, 8'd0, '0, 1'b0));
      send_word(req_of(OP_ENABLE, 8'd15, '1, 1'b1));
      send_word(req_of(OP_ENABLE, 8'd48, '0, 1'b0));
      send_word(req_of(OP_DISABLE, 8'd255, '0, 1'b0));
      send_word(req_of(OP_ENABLE, 8'd16, '0, 1'b0));
      send_word(req_of(OP_ENABLE, 8'd47, '0, 1'b0));
      send_word(req_of(OP_ACK, 8'd0, '0, 1'b0));
      send_word(req_of(OP_ACK, 8'd0, '1, 1'b0));
      send_word(req_of(OP_ACK, 8'd0, '1, 1'b0));
      send_word(req_of(OP_EOS, 8'd0, '0, 1'b0));
      for (int s = 23; s <= 26; s++) send_word(req_of(OP_ENABLE, 8'(16 + s), '0, 1'b0));
      // top pending bit not at the highest level: lowest index at that level wins
      send_word(req_of(OP_ACK, 8'd0, 32'h0780_0000, 1'b0));
      send_word(req_of(OP_ACK, 8'd0, 32'h0400_0000, 1'b0));
      send_word(req_of(OP_EOS, 8'd0, '0, 1'b1));
      send_word(req_of(OP_EOS, 8'd0, '0, 1'b0));
      send_word(req_of(OP_ACK, 8'd0, 32'h0000_0001, 1'b0));
      send_word(req_of(OP_ENABLE, 8'd17, '0, 1'b0));
      send_word(req_of(OP_DISABLE, 8'd47, '0, 1'b0));
      send_word(req_of(OP_EOS, 8'd0, '0, 1'b0));
      send_word(req_of(OP_DISABLE, 8'd17, '0, 1'b0));
   endtask

   // one source per level, so the stack fills to its full depth
   task automatic test_deep_nesting();
      int chain [NEST_LIMIT] = '{0, 2, 4, 6, 8, 10, 12, 14, 16, 18, 20, 21, 22, 23, 30, 31};
      for (int s = 0; s < SOURCES; s++)
         send_word(req_of(OP_ENABLE, base_setting + 8'(s), '0, 1'b0));
      for (int k = 0; k < NEST_LIMIT; k++)
         send_word(req_of(OP_ACK, 8'd0, 32'd1 << chain[k], 1'b0));
      send_word(req_of(OP_ACK, 8'd0, '1, 1'b0));
      for (int k = 0; k < NEST_LIMIT; k++)
         send_word(req_of(OP_EOS, 8'd0, '0, 1'($urandom_range(0, 1))));
      send_word(req_of(OP_EOS, 8'd0, '0, 1'b0));
   endtask

   task automatic test_random_at_base(input logic [7:0] value, input int n_items);
      drain_results();
      write_base(value);
      random_traffic(n_items);
   endtask

   task automatic test_receiver_hold();
      idle_on = 1'b0;
      hold_request <= 1'b1;
      random_traffic(30);
      drain_results();
      idle_on = 1'b1;
   endtask

   task automatic test_steady_stream();
      drain_results();
      write_base(BASE_AT_RESET);
      idle_on = 1'b0;
      random_traffic(100);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_deep_nesting();
      test_random_at_base(8'd0, 120);
      test_random_at_base(8'd224, 100);
      test_receiver_hold();
      test_random_at_base(8'($urandom_range(1, 223)), 150);
      test_steady_stream();
      drain_results();
      if (mismatch_count == 0 && rsp_expect_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
